@@ sv/spi_flash_command_sequencer_defines.svh @@
// Assertion macros for the serial flash command sequencer checkers.
// Needs nothing else; include it in files that hold concurrent assertions.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SPIFCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SPIFCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/spifcs_pkg.sv @@
// Shared types and constants of the serial flash command sequencer.
// Used by the front, queue, back, top level and checker; depends on nothing.
package spifcs_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_WDATA   = 2'd1,
    KIND_RX      = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_ERASE   = 2'd2,
    OP_IDENT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_SEND    = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_READ    = 3'd2,
    ACT_DONE    = 3'd3,
    ACT_REJECT  = 3'd4
  } action_e;

  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h20;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] CMD_IDENT   = 8'hAB;
  localparam logic [7:0] STATUS_BUSY = 8'h01;

  // All results caused by one input transfer.
  typedef struct packed {
    logic [1:0]                      count;
    action_e [MAX_RESULTS-1:0]       action;
    logic [MAX_RESULTS-1:0][7:0]     value;
  } bundle_t;

  // Head of the result queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } qhead_t;

endpackage

@@ sv/spifcs_queue.sv @@
// Short queue of result bundles between the front and the back end.
// Depends on spifcs_pkg for the bundle types.
module spifcs_queue import spifcs_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output qhead_t  head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && (count_q != '0);

  assign head_o.valid  = (count_q != '0);
  assign head_o.bundle = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/spifcs_front.sv @@
// Front end: accepts input transfers, runs the command phase machine and
// builds the bundle of results for each transfer. Depends on spifcs_pkg.
module spifcs_front import spifcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  op_i,
  input  logic [23:0] address_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output bundle_t     push_data_o
);

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_WREN        = 4'd1,
    PH_HEADER      = 4'd2,
    PH_DATA_RX     = 4'd3,
    PH_HOST_WAIT   = 4'd4,
    PH_PROG_RX     = 4'd5,
    PH_STATUS_CMD  = 4'd6,
    PH_STATUS_POLL = 4'd7,
    PH_IDENT       = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  operation_q, operation_d;
  logic [23:0] flash_address_q, flash_address_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [2:0]  header_index_q, header_index_d;
  logic [2:0]  hi_inc;
  logic [15:0] bl_dec;
  logic [7:0]  addr_byte;
  bundle_t     bnd;

  assign hi_inc = header_index_q + 3'd1;
  assign bl_dec = bytes_left_q - 16'd1;

  always_comb begin
    case (hi_inc)
      3'd1:    addr_byte = flash_address_q[23:16];
      3'd2:    addr_byte = flash_address_q[15:8];
      default: addr_byte = flash_address_q[7:0];
    endcase
  end

  always_comb begin
    phase_d         = phase_q;
    operation_d     = operation_q;
    flash_address_d = flash_address_q;
    bytes_left_d    = bytes_left_q;
    header_index_d  = header_index_q;
    bnd             = '0;
    unique case (kind_i)
      KIND_REQUEST: begin
        bnd.count = 2'd1;
        if (phase_q != PH_IDLE) begin
          bnd.action[0] = ACT_REJECT;
        end else begin
          operation_d     = op_i;
          flash_address_d = address_i;
          bytes_left_d    = length_i;
          header_index_d  = 3'd0;
          bnd.action[0]   = ACT_SEND;
          if (op_i == OP_READ) begin
            bnd.value[0] = CMD_READ;
            phase_d      = PH_HEADER;
          end else if (op_i == OP_IDENT) begin
            bnd.value[0] = CMD_IDENT;
            phase_d      = PH_IDENT;
          end else begin
            bnd.value[0] = CMD_WREN;
            phase_d      = PH_WREN;
          end
        end
      end
      KIND_WDATA: begin
        bnd.count = 2'd1;
        if (phase_q != PH_HOST_WAIT) begin
          bnd.action[0] = ACT_REJECT;
        end else begin
          bnd.action[0] = ACT_SEND;
          bnd.value[0]  = write_data_i;
          phase_d       = PH_PROG_RX;
        end
      end
      KIND_RX: begin
        unique case (phase_q)
          PH_WREN: begin
            bnd.count      = 2'd2;
            bnd.action[0]  = ACT_RELEASE;
            bnd.action[1]  = ACT_SEND;
            bnd.value[1]   = (operation_q == OP_PROGRAM) ? CMD_PROGRAM : CMD_ERASE;
            header_index_d = 3'd0;
            phase_d        = PH_HEADER;
          end
          PH_HEADER: begin
            if (header_index_q < 3'd3) begin
              header_index_d = hi_inc;
              bnd.count      = 2'd1;
              bnd.action[0]  = ACT_SEND;
              bnd.value[0]   = addr_byte;
            end else if (operation_q == OP_READ) begin
              if (bytes_left_q == 16'd0) begin
                bnd.count     = 2'd2;
                bnd.action[0] = ACT_RELEASE;
                bnd.action[1] = ACT_DONE;
                phase_d       = PH_IDLE;
              end else begin
                bnd.count     = 2'd1;
                bnd.action[0] = ACT_SEND;
                phase_d       = PH_DATA_RX;
              end
            end else if (operation_q == OP_PROGRAM && bytes_left_q != 16'd0) begin
              phase_d = PH_HOST_WAIT;
            end else begin
              bnd.count     = 2'd2;
              bnd.action[0] = ACT_RELEASE;
              bnd.action[1] = ACT_SEND;
              bnd.value[1]  = CMD_STATUS;
              phase_d       = PH_STATUS_CMD;
            end
          end
          PH_DATA_RX: begin
            bytes_left_d  = bl_dec;
            bnd.action[0] = ACT_READ;
            bnd.value[0]  = rx_byte_i;
            if (bl_dec == 16'd0) begin
              bnd.count     = 2'd3;
              bnd.action[1] = ACT_RELEASE;
              bnd.action[2] = ACT_DONE;
              phase_d       = PH_IDLE;
            end else begin
              bnd.count     = 2'd2;
              bnd.action[1] = ACT_SEND;
            end
          end
          PH_PROG_RX: begin
            bytes_left_d = bl_dec;
            if (bl_dec == 16'd0) begin
              bnd.count     = 2'd2;
              bnd.action[0] = ACT_RELEASE;
              bnd.action[1] = ACT_SEND;
              bnd.value[1]  = CMD_STATUS;
              phase_d       = PH_STATUS_CMD;
            end else begin
              phase_d = PH_HOST_WAIT;
            end
          end
          PH_STATUS_CMD: begin
            bnd.count     = 2'd1;
            bnd.action[0] = ACT_SEND;
            phase_d       = PH_STATUS_POLL;
          end
          PH_STATUS_POLL: begin
            if ((rx_byte_i & STATUS_BUSY) != 8'd0) begin
              bnd.count     = 2'd1;
              bnd.action[0] = ACT_SEND;
            end else begin
              bnd.count     = 2'd2;
              bnd.action[0] = ACT_RELEASE;
              bnd.action[1] = ACT_DONE;
              phase_d       = PH_IDLE;
            end
          end
          PH_IDENT: begin
            if (header_index_q < 3'd4) begin
              header_index_d = hi_inc;
              bnd.count      = 2'd1;
              bnd.action[0]  = ACT_SEND;
            end else begin
              bnd.count     = 2'd3;
              bnd.action[0] = ACT_READ;
              bnd.value[0]  = rx_byte_i;
              bnd.action[1] = ACT_RELEASE;
              bnd.action[2] = ACT_DONE;
              phase_d       = PH_IDLE;
            end
          end
          default: begin
            bnd.count     = 2'd1;
            bnd.action[0] = ACT_REJECT;
          end
        endcase
      end
      default: begin
        bnd.count     = 2'd1;
        bnd.action[0] = ACT_REJECT;
      end
    endcase
  end

  assign push_o      = accept_i && (bnd.count != 2'd0);
  assign push_data_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      operation_q     <= 2'd0;
      flash_address_q <= 24'd0;
      bytes_left_q    <= 16'd0;
      header_index_q  <= 3'd0;
    end else if (accept_i) begin
      phase_q         <= phase_d;
      operation_q     <= operation_d;
      flash_address_q <= flash_address_d;
      bytes_left_q    <= bytes_left_d;
      header_index_q  <= header_index_d;
    end
  end

endmodule

@@ sv/spifcs_back.sv @@
// Back end: takes result bundles from the queue and hands them out one
// result per transfer through the output register. Depends on spifcs_pkg.
module spifcs_back import spifcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qhead_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  logic       out_valid_q, out_valid_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] action_q;
  logic [7:0] value_q;
  logic       last_q;
  logic       load;
  logic       is_last;

  assign load    = !out_valid_q || !out_stall_i;
  assign is_last = (idx_q == (head_i.bundle.count - 2'd1));

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_i.valid;
      if (head_i.valid) begin
        pop_o = is_last;
        idx_d = is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      action_q <= head_i.bundle.action[idx_q];
      value_q  <= head_i.bundle.value[idx_q];
      last_q   <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

@@ sv/spi_flash_command_sequencer.sv @@
// Serial NOR flash command sequencer: one input transfer per cycle while the
// result queue has room; results leave one per cycle while out_stall_i is low,
// so the results of one transfer leave one after another. The input stalls
// only when the four-entry result queue between the phase machine and the
// output register is full; a transfer that causes no result never enters the
// queue. Depends on spifcs_pkg, spifcs_front, spifcs_queue and spifcs_back.
module spi_flash_command_sequencer import spifcs_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  op_i,
  input  logic [23:0] address_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  value_o,
  output logic        last_o
);

  logic    full;
  logic    accept;
  logic    push;
  logic    pop;
  bundle_t push_data;
  qhead_t  head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  spifcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .op_i         (op_i),
    .address_i    (address_i),
    .length_i     (length_i),
    .write_data_i (write_data_i),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  spifcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head)
  );

  spifcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/spifcs_checker.sv @@
// Port-level checker for the serial flash command sequencer, bound to the top.
// Depends on spifcs_pkg and spi_flash_command_sequencer_defines.svh.
`include "spi_flash_command_sequencer_defines.svh"

module spifcs_checker import spifcs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] value_o,
  input logic       last_o
);

  logic        rej_seen, done_seen, rel_seen, held, last_zero, more_zero;
  logic [12:0] out_word;

  assign rej_seen  = out_valid_o && (action_o == ACT_REJECT);
  assign done_seen = out_valid_o && (action_o == ACT_DONE);
  assign rel_seen  = out_valid_o && (action_o == ACT_RELEASE);
  assign held      = out_valid_o && out_stall_i;
  assign last_zero = last_o && (value_o == 8'd0);
  assign more_zero = !last_o && (value_o == 8'd0);
  assign out_word  = {out_valid_o, action_o, value_o, last_o};

  `SPIFCS_ASSERT_IMP(a_reject_alone, clk_i, rst_ni, rej_seen, last_zero, "Reject not alone.")
  `SPIFCS_ASSERT_IMP(a_done_last, clk_i, rst_ni, done_seen, last_zero, "Done not last.")
  `SPIFCS_ASSERT_IMP(a_release_followed, clk_i, rst_ni, rel_seen, more_zero, "Release was last.")
  `SPIFCS_ASSERT_NXT(a_hold, clk_i, rst_ni, held, $stable(out_word), "Held result moved.")

endmodule

bind spi_flash_command_sequencer spifcs_checker u_spifcs_checker (.*);

@@ verif/spi_flash_command_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the serial flash command sequencer: a directed table, then
// random command sequences, checked against a predictor of the phase machine.
// Depends on spifcs_pkg and spi_flash_command_sequencer.
module spi_flash_command_sequencer_tb;
  import spifcs_pkg::*;

  localparam int DIRECTED_ROWS = 32;
  localparam int RANDOM_ITEMS = 78;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_WREN,
    SEQ_HEADER,
    SEQ_READ_DATA,
    SEQ_HOST_WAIT,
    SEQ_PROG_ACK,
    SEQ_STATUS_CMD,
    SEQ_STATUS_POLL,
    SEQ_IDENT
  } seq_phase_e;

  typedef struct packed {
    kind_e       kind;
    op_e         op;
    logic [23:0] addr;
    logic [15:0] len;
    logic [7:0]  wdata;
    logic [7:0]  rxb;
    logic        typed;
    action_e     exp_action;
    logic [7:0]  exp_value;
  } stim_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] value;
    logic       last;
  } flash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [1:0]  op_i;
  logic [23:0] address_i;
  logic [15:0] length_i;
  logic [7:0]  write_data_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic [7:0]  value_o;
  logic        last_o;

  seq_phase_e    seq_phase;
  op_e           seq_op;
  logic [23:0]   seq_addr;
  logic [15:0]   seq_left;
  logic [2:0]    seq_hdr;
  flash_result_t step_results[$];
  flash_result_t expected_results[$];
  stim_t         directed_table [DIRECTED_ROWS];

  int idle_mode = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit pressure_request = 1'b0;
  bit pressure_done = 1'b0;

  spi_flash_command_sequencer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .op_i         (op_i),
    .address_i    (address_i),
    .length_i     (length_i),
    .write_data_i (write_data_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic stim_t stim_row(kind_e k, op_e o, logic [23:0] a, logic [15:0] n,
                                     logic [7:0] wd, logic [7:0] rx, logic typed,
                                     action_e act, logic [7:0] val);
    stim_t s;
    s = '{k, o, a, n, wd, rx, typed, act, val};
    return s;
  endfunction

  function automatic stim_t rx_row(logic [7:0] rx);
    return stim_row(KIND_RX, OP_READ, 24'h0, 16'h0, 8'h00, rx, 1'b0, ACT_SEND, 8'h00);
  endfunction

  function automatic void add_result(action_e a, logic [7:0] v);
    flash_result_t r;
    r.action = a;
    r.value = v;
    r.last = 1'b0;
    if (step_results.size() < MAX_RESULTS) step_results.push_back(r);
  endfunction

  function automatic void release_and_poll();
    add_result(ACT_RELEASE, 8'h00);
    add_result(ACT_SEND, CMD_STATUS);
    seq_phase = SEQ_STATUS_CMD;
  endfunction

  function automatic void release_and_done();
    add_result(ACT_RELEASE, 8'h00);
    add_result(ACT_DONE, 8'h00);
    seq_phase = SEQ_IDLE;
  endfunction

  function automatic void header_sent();
    case (seq_op)
      OP_READ: begin
        if (seq_left == 16'd0) begin
          release_and_done();
        end else begin
          add_result(ACT_SEND, 8'h00);
          seq_phase = SEQ_READ_DATA;
        end
      end
      OP_PROGRAM: begin
        if (seq_left == 16'd0) release_and_poll();
        else seq_phase = SEQ_HOST_WAIT;
      end
      default: release_and_poll();
    endcase
  endfunction

  function automatic void flash_byte(logic [7:0] rx);
    case (seq_phase)
      SEQ_WREN: begin
        add_result(ACT_RELEASE, 8'h00);
        add_result(ACT_SEND, (seq_op == OP_PROGRAM) ? CMD_PROGRAM : CMD_ERASE);
        seq_hdr = 3'd0;
        seq_phase = SEQ_HEADER;
      end
      SEQ_HEADER: begin
        if (seq_hdr < 3'd3) begin
          seq_hdr = seq_hdr + 3'd1;
          add_result(ACT_SEND, 8'(seq_addr >> (8 * (3 - int'(seq_hdr)))));
        end else begin
          header_sent();
        end
      end
      SEQ_READ_DATA: begin
        add_result(ACT_READ, rx);
        seq_left = seq_left - 16'd1;
        if (seq_left == 16'd0) release_and_done();
        else add_result(ACT_SEND, 8'h00);
      end
      SEQ_PROG_ACK: begin
        seq_left = seq_left - 16'd1;
        if (seq_left == 16'd0) release_and_poll();
        else seq_phase = SEQ_HOST_WAIT;
      end
      SEQ_STATUS_CMD: begin
        add_result(ACT_SEND, 8'h00);
        seq_phase = SEQ_STATUS_POLL;
      end
      SEQ_STATUS_POLL: begin
        if ((rx & STATUS_BUSY) != 8'h00) add_result(ACT_SEND, 8'h00);
        else release_and_done();
      end
      SEQ_IDENT: begin
        if (seq_hdr < 3'd4) begin
          seq_hdr = seq_hdr + 3'd1;
          add_result(ACT_SEND, 8'h00);
        end else begin
          add_result(ACT_READ, rx);
          release_and_done();
        end
      end
      default: add_result(ACT_REJECT, 8'h00);
    endcase
  endfunction

  function automatic void predict_transfer(stim_t it);
    flash_result_t r;
    step_results.delete();
    case (it.kind)
      KIND_REQUEST: begin
        if (seq_phase != SEQ_IDLE) begin
          add_result(ACT_REJECT, 8'h00);
        end else begin
          seq_op = it.op;
          seq_addr = it.addr;
          seq_left = it.len;
          seq_hdr = 3'd0;
          if (it.op == OP_READ) begin
            add_result(ACT_SEND, CMD_READ);
            seq_phase = SEQ_HEADER;
          end else if (it.op == OP_IDENT) begin
            add_result(ACT_SEND, CMD_IDENT);
            seq_phase = SEQ_IDENT;
          end else begin
            add_result(ACT_SEND, CMD_WREN);
            seq_phase = SEQ_WREN;
          end
        end
      end
      KIND_WDATA: begin
        if (seq_phase != SEQ_HOST_WAIT) begin
          add_result(ACT_REJECT, 8'h00);
        end else begin
          add_result(ACT_SEND, it.wdata);
          seq_phase = SEQ_PROG_ACK;
        end
      end
      KIND_RX: begin
        if (seq_phase == SEQ_IDLE || seq_phase == SEQ_HOST_WAIT) add_result(ACT_REJECT, 8'h00);
        else flash_byte(it.rxb);
      end
      default: add_result(ACT_REJECT, 8'h00);
    endcase
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    if (it.typed) begin
      r.action = it.exp_action;
      r.value = it.exp_value;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
  endfunction

  // Mostly well-formed command sequences; about one item in seven is random noise.
  function automatic stim_t pick_random_item();
    stim_t it;
    it = stim_row(KIND_RX, op_e'($urandom_range(3)), 24'($urandom()), 16'($urandom()),
                  8'($urandom()), 8'($urandom()), 1'b0, ACT_SEND, 8'h00);
    if ($urandom_range(99) < 15) it.kind = kind_e'($urandom_range(3));
    else if (seq_phase == SEQ_IDLE) it.kind = KIND_REQUEST;
    else if (seq_phase == SEQ_HOST_WAIT) it.kind = KIND_WDATA;
    if (it.op == OP_READ || it.op == OP_PROGRAM) it.len = 16'($urandom_range(3));
    return it;
  endfunction

  function automatic int send_idle_pct();
    return (idle_mode == 0) ? 12 : (idle_mode == 1) ? 68 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (idle_mode == 0) ? 68 : (idle_mode == 1) ? 12 : 0;
  endfunction

  task automatic offer_item(stim_t it);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= it.kind;
    op_i         <= it.op;
    address_i    <= it.addr;
    length_i     <= it.len;
    write_data_i <= it.wdata;
    rx_byte_i    <= it.rxb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transfer(it);
  endtask

  function automatic void check_flash_result();
    flash_result_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result, expected none, actual action %0d value %02h last %0b",
               $time, action_o, value_o, last_o);
      return;
    end
    want = expected_results.pop_front();
    if (action_o !== want.action) begin
      error_count++;
      $display("%0t: action mismatch, expected %0d, actual %0d", $time, want.action, action_o);
    end
    if (value_o !== want.value) begin
      error_count++;
      $display("%0t: value mismatch, expected %02h, actual %02h", $time, want.value, value_o);
    end
    if (last_o !== want.last) begin
      error_count++;
      $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last_o);
    end
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_flash_result();
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (pressure_request && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct());
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_REQUEST;
    op_i         <= OP_READ;
    address_i    <= 24'h0;
    length_i     <= 16'h0;
    write_data_i <= 8'h00;
    rx_byte_i    <= 8'h00;
    seq_phase = SEQ_IDLE;
    seq_op = OP_READ;
    seq_addr = 24'h0;
    seq_left = 16'h0;
    seq_hdr = 3'd0;
    directed_table = '{
      stim_row(KIND_RX, OP_READ, 24'h0, 16'h0, 8'h00, 8'hAA, 1'b1, ACT_REJECT, 8'h00),
      stim_row(KIND_WDATA, OP_READ, 24'h0, 16'h0, 8'hFF, 8'h00, 1'b1, ACT_REJECT, 8'h00),
      stim_row(KIND_RSVD, OP_IDENT, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, ACT_REJECT,
               8'h00),
      stim_row(KIND_REQUEST, OP_IDENT, 24'hFFFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1, ACT_SEND,
               CMD_IDENT),
      stim_row(KIND_REQUEST, OP_READ, 24'h0, 16'h0, 8'h00, 8'h00, 1'b1, ACT_REJECT, 8'h00),
      rx_row(8'h00), rx_row(8'h11), rx_row(8'h22), rx_row(8'h33), rx_row(8'hFF),
      stim_row(KIND_REQUEST, OP_READ, 24'hFFFFFF, 16'h0000, 8'h00, 8'h00, 1'b1, ACT_SEND,
               CMD_READ),
      rx_row(8'h5A), rx_row(8'hC3), rx_row(8'h0F), rx_row(8'hF0),
      stim_row(KIND_REQUEST, OP_PROGRAM, 24'h000000, 16'h0000, 8'h00, 8'h00, 1'b1, ACT_SEND,
               CMD_WREN),
      rx_row(8'h00), rx_row(8'h00), rx_row(8'h00), rx_row(8'h00), rx_row(8'h00),
      rx_row(8'h00), rx_row(8'h01), rx_row(8'hFE),
      stim_row(KIND_REQUEST, OP_ERASE, 24'h5AA53C, 16'h1234, 8'h00, 8'h00, 1'b1, ACT_SEND,
               CMD_WREN),
      rx_row(8'h00), rx_row(8'h00), rx_row(8'h00), rx_row(8'h00), rx_row(8'h00),
      rx_row(8'hFF), rx_row(8'h00)
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_table[i]) offer_item(directed_table[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_mode = 1;
      if (n == 2 * RANDOM_ITEMS / 3) begin
        idle_mode = 2;
        pressure_request = 1'b1;
      end
      offer_item(pick_random_item());
    end
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/spifcs_pkg.sv
sv/spifcs_queue.sv
sv/spifcs_front.sv
sv/spifcs_back.sv
sv/spi_flash_command_sequencer.sv
sv/spifcs_checker.sv
verif/spi_flash_command_sequencer_tb.sv
